// ===== sv/length_prefixed_record_fifo_top_defines.svh =====
// Assertion macros used by the record FIFO datapath.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef LENGTH_PREFIXED_RECORD_FIFO_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define LPRF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lprf assertion failed");
// condition never holds outside reset
`define LPRF_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lprf forbidden condition");
`else
`define LPRF_ASSERT(lbl, clk, rst, prop)
`define LPRF_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== sv/lprf_pkg.sv =====
// Shared constants, codes and control types of the record FIFO.
// Used by the interfaces, controller, datapath and top level.
package lprf_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int MAX_RECORD = 64;
  localparam int LEN_W      = 7;
  localparam int LG_W       = 4;
  localparam int CNT_W      = 10;
  localparam int LG_MIN     = 2;
  localparam int LG_TOP     = (IDX_W < 10) ? IDX_W : 10;

  // actions
  localparam logic [2:0] ACT_PUSH_BEGIN = 3'd0;
  localparam logic [2:0] ACT_PUSH_BYTE  = 3'd1;
  localparam logic [2:0] ACT_SHIFT      = 3'd2;
  localparam logic [2:0] ACT_PEEK       = 3'd3;
  localparam logic [2:0] ACT_DISCARD    = 3'd4;
  localparam logic [2:0] ACT_ITER_START = 3'd5;
  localparam logic [2:0] ACT_ITER_NEXT  = 3'd6;

  // drop policies
  localparam logic [1:0] POL_HEAD = 2'd0;
  localparam logic [1:0] POL_TAIL = 2'd1;
  localparam logic [1:0] POL_ALL  = 2'd2;

  // result status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_LONG   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_OVER_LIMIT = 3'd4;
  localparam logic [2:0] ST_BAD_POLICY = 3'd5;
  localparam logic [2:0] ST_PUSH_OPEN  = 3'd6;

  typedef enum logic [1:0] {LEN_ZERO, LEN_RLEN, LEN_BTP, LEN_HDR} len_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_HDR0, S_HDR1, S_PBYTE, S_PURGE, S_RH0, S_RH1,
    S_RH2, S_RCHK, S_RD_A, S_RD_E, S_EMIT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       drop_all;
    logic       iter_start;
    logic       ptr_tail;
    logic       ptr_itail;
    logic       mem_rd;
    logic       hdr_hi;
    logic       hdr_lo;
    logic       guard_clr;
    logic       commit;
    logic       cnt_clr;
    logic       hdr_wr0;
    logic       hdr_wr1;
    logic       pbyte;
    logic       emit_single;
    logic       emit_data;
    logic [2:0] res_status;
    len_sel_t   res_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] policy;
    logic       btp_zero;
    logic       too_long;
    logic       no_space;
    logic       used_zero;
    logic       iused_zero;
    logic       over_limit;
    logic       hdr_zero;
    logic       purge_go;
    logic       last_byte;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/lprf_cmd_if.sv =====
// Request channel of the record FIFO: valid/ready plus one item's fields.
// Depends on lprf_pkg.
interface lprf_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  action;
  logic [lprf_pkg::LEN_W-1:0]  record_length;
  logic [1:0]                  drop_policy;
  logic [7:0]                  data_byte;
  logic [lprf_pkg::LEN_W-1:0]  read_limit;

  modport source (output valid, action, record_length, drop_policy, data_byte,
                  read_limit, input ready);
  modport sink (input valid, action, record_length, drop_policy, data_byte,
                read_limit, output ready);
endinterface

// ===== sv/lprf_rsp_if.sv =====
// Result channel of the record FIFO: valid/ready plus one result's fields.
// Depends on lprf_pkg.
interface lprf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [7:0]                  out_byte;
  logic [lprf_pkg::LEN_W-1:0]  out_length;
  logic                        byte_valid;
  logic                        last;
  logic [lprf_pkg::CNT_W-1:0]  record_count;

  modport source (output valid, status, out_byte, out_length, byte_valid, last,
                  record_count, input ready);
  modport sink (input valid, status, out_byte, out_length, byte_valid, last,
                record_count, output ready);
endinterface

// ===== sv/length_prefixed_record_fifo_top.sv =====
// Record FIFO top level: a byte ring holding length-prefixed records.
// A request on cmd is taken only while the block is idle. A status-only item passes
// decode and emit; a push byte adds a ring write; a push begin adds two header writes,
// and under head drop a purge check plus a header read and check per record purged. A
// read fetches the two header bytes, checks the header, then reads and emits each payload
// byte through the single ring read port with registered data; a zero-length, over-limit
// or discard read emits one result after the check. Results leave through one output
// register, so a stalled rsp holds the sequencer only when a new result is ready to load.
// Depends on lprf_pkg, lprf_cmd_if, lprf_rsp_if, lprf_ctrl and lprf_dp.
module length_prefixed_record_fifo_top (
  input  logic                       clk,
  input  logic                       rst,
  lprf_cmd_if.sink                   cmd,
  lprf_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [lprf_pkg::LG_W-1:0]  cfg_data
);

  lprf_pkg::cmd_t  ctl;
  lprf_pkg::stat_t st;
  logic            ready;

  assign cmd.ready = ready;

  lprf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (ready),
    .st        (st),
    .cmd       (ctl)
  );

  lprf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .action        (cmd.action),
    .record_length (cmd.record_length),
    .drop_policy   (cmd.drop_policy),
    .data_byte     (cmd.data_byte),
    .read_limit    (cmd.read_limit),
    .cmd           (ctl),
    .st            (st),
    .rsp           (rsp)
  );

endmodule

// ===== sv/lprf_ctrl.sv =====
// Sequencer of the record FIFO: steps each item through decode, memory
// accesses and result emission. Depends on lprf_pkg.
module lprf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  lprf_pkg::stat_t st,
  output lprf_pkg::cmd_t  cmd
);

  lprf_pkg::state_t   state, state_next;
  logic [2:0]         res_status, res_status_next;
  lprf_pkg::len_sel_t res_sel, res_sel_next;

  // state and held result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lprf_pkg::S_IDLE;
      res_status <= lprf_pkg::ST_OK;
      res_sel    <= lprf_pkg::LEN_ZERO;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_sel    <= res_sel_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_sel_next    = res_sel;
    cmd             = '0;
    cmd.res_status  = res_status;
    cmd.res_sel     = res_sel;
    cmd_ready       = 1'b0;
    unique case (state)
      lprf_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd.capture = 1'b1;
          state_next  = lprf_pkg::S_DECODE;
        end
      end
      lprf_pkg::S_DECODE: begin
        state_next      = lprf_pkg::S_EMIT;
        res_status_next = lprf_pkg::ST_OK;
        res_sel_next    = lprf_pkg::LEN_ZERO;
        unique case (st.action)
          lprf_pkg::ACT_PUSH_BEGIN: begin
            if (!st.btp_zero) begin
              res_status_next = lprf_pkg::ST_PUSH_OPEN;
            end else if (st.too_long) begin
              res_status_next = lprf_pkg::ST_TOO_LONG;
            end else begin
              case (st.policy)
                lprf_pkg::POL_TAIL: begin
                  if (st.no_space) res_status_next = lprf_pkg::ST_NO_SPACE;
                  else state_next = lprf_pkg::S_HDR0;
                end
                lprf_pkg::POL_HEAD: begin
                  cmd.guard_clr = 1'b1;
                  state_next    = lprf_pkg::S_PURGE;
                end
                lprf_pkg::POL_ALL: begin
                  cmd.drop_all = 1'b1;
                  state_next   = lprf_pkg::S_HDR0;
                end
                default: res_status_next = lprf_pkg::ST_BAD_POLICY;
              endcase
            end
          end
          lprf_pkg::ACT_PUSH_BYTE: begin
            if (st.btp_zero) res_status_next = lprf_pkg::ST_EMPTY;
            else state_next = lprf_pkg::S_PBYTE;
          end
          lprf_pkg::ACT_SHIFT, lprf_pkg::ACT_PEEK, lprf_pkg::ACT_DISCARD: begin
            if (st.used_zero) begin
              res_status_next = lprf_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_tail = 1'b1;
              state_next   = lprf_pkg::S_RH0;
            end
          end
          lprf_pkg::ACT_ITER_START: begin
            cmd.iter_start = 1'b1;
          end
          lprf_pkg::ACT_ITER_NEXT: begin
            if (st.iused_zero) begin
              res_status_next = lprf_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_itail = 1'b1;
              state_next    = lprf_pkg::S_RH0;
            end
          end
          default: ;
        endcase
      end
      lprf_pkg::S_HDR0: begin
        cmd.hdr_wr0 = 1'b1;
        state_next  = lprf_pkg::S_HDR1;
      end
      lprf_pkg::S_HDR1: begin
        cmd.hdr_wr1     = 1'b1;
        res_status_next = lprf_pkg::ST_OK;
        res_sel_next    = lprf_pkg::LEN_RLEN;
        state_next      = lprf_pkg::S_EMIT;
      end
      lprf_pkg::S_PBYTE: begin
        cmd.pbyte       = 1'b1;
        res_status_next = lprf_pkg::ST_OK;
        res_sel_next    = lprf_pkg::LEN_BTP;
        state_next      = lprf_pkg::S_EMIT;
      end
      lprf_pkg::S_PURGE: begin
        if (st.purge_go) begin
          cmd.ptr_tail = 1'b1;
          state_next   = lprf_pkg::S_RH0;
        end else begin
          state_next = lprf_pkg::S_HDR0;
        end
      end
      lprf_pkg::S_RH0: begin
        cmd.mem_rd = 1'b1;
        state_next = lprf_pkg::S_RH1;
      end
      lprf_pkg::S_RH1: begin
        cmd.hdr_hi = 1'b1;
        cmd.mem_rd = 1'b1;
        state_next = lprf_pkg::S_RH2;
      end
      lprf_pkg::S_RH2: begin
        cmd.hdr_lo = 1'b1;
        state_next = lprf_pkg::S_RCHK;
      end
      lprf_pkg::S_RCHK: begin
        state_next      = lprf_pkg::S_EMIT;
        res_status_next = lprf_pkg::ST_OK;
        res_sel_next    = lprf_pkg::LEN_ZERO;
        case (st.action)
          lprf_pkg::ACT_PUSH_BEGIN: begin
            cmd.commit = 1'b1;
            state_next = lprf_pkg::S_PURGE;
          end
          lprf_pkg::ACT_DISCARD: begin
            cmd.commit   = 1'b1;
            res_sel_next = lprf_pkg::LEN_HDR;
          end
          default: begin
            if (st.over_limit) begin
              res_status_next = lprf_pkg::ST_OVER_LIMIT;
              res_sel_next    = lprf_pkg::LEN_HDR;
            end else begin
              cmd.commit  = 1'b1;
              cmd.cnt_clr = 1'b1;
              if (!st.hdr_zero) state_next = lprf_pkg::S_RD_A;
            end
          end
        endcase
      end
      lprf_pkg::S_RD_A: begin
        cmd.mem_rd = 1'b1;
        state_next = lprf_pkg::S_RD_E;
      end
      lprf_pkg::S_RD_E: begin
        if (st.out_free) begin
          cmd.emit_data = 1'b1;
          state_next    = st.last_byte ? lprf_pkg::S_IDLE : lprf_pkg::S_RD_A;
        end
      end
      lprf_pkg::S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = lprf_pkg::S_IDLE;
        end
      end
      default: state_next = lprf_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/lprf_dp.sv =====
// Datapath of the record FIFO: byte ring memory, indexes, header and
// output registers. Depends on lprf_pkg, lprf_rsp_if and the defines header.
`include "length_prefixed_record_fifo_top_defines.svh"
module lprf_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lprf_pkg::LG_W-1:0]   cfg_data,
  input  logic [2:0]                  action,
  input  logic [lprf_pkg::LEN_W-1:0]  record_length,
  input  logic [1:0]                  drop_policy,
  input  logic [7:0]                  data_byte,
  input  logic [lprf_pkg::LEN_W-1:0]  read_limit,
  input  lprf_pkg::cmd_t              cmd,
  output lprf_pkg::stat_t             st,
  lprf_rsp_if.source                  rsp
);

  localparam int IW = lprf_pkg::IDX_W;
  localparam int LW = lprf_pkg::LEN_W;
  localparam int CW = IW + 8;

  logic [7:0]    ring [lprf_pkg::RING_DEPTH];
  logic [7:0]    rdata;

  logic [lprf_pkg::LG_W-1:0] lg;
  logic [IW-1:0] head, tail, wcur, itail, ihead, ptr;
  logic [LW-1:0] btp;
  logic [lprf_pkg::CNT_W-1:0] recs;
  logic [2:0]    act_q;
  logic [LW-1:0] rlen_q, limit_q;
  logic [1:0]    pol_q;
  logic [7:0]    dbyte_q;
  logic [15:0]   hdr;
  logic [LW-1:0] cnt;
  logic [IW:0]   guard;

  logic [lprf_pkg::LG_W-1:0] lg_eff;
  logic [IW:0]   size;
  logic [IW-1:0] mask, free_b, used_b, iused_b, adv_tail, adv_itail;
  logic [7:0]    need;
  logic [LW-1:0] limit_eff, hdr_sat, len_mux;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          out_free;

  // ring geometry
  always_comb begin
    lg_eff = lg;
    if (lg < lprf_pkg::LG_W'(lprf_pkg::LG_MIN)) lg_eff = lprf_pkg::LG_W'(lprf_pkg::LG_MIN);
    if (lg > lprf_pkg::LG_W'(lprf_pkg::LG_TOP)) lg_eff = lprf_pkg::LG_W'(lprf_pkg::LG_TOP);
  end
  assign size      = (IW+1)'(1) << lg_eff;
  assign mask      = IW'(size - (IW+1)'(1));
  assign free_b    = (tail - head - IW'(1)) & mask;
  assign used_b    = (head - tail) & mask;
  assign iused_b   = (ihead - itail) & mask;
  assign need      = 8'(rlen_q) + 8'd2;
  assign adv_tail  = (tail + IW'(hdr) + IW'(2)) & mask;
  assign adv_itail = (itail + IW'(hdr) + IW'(2)) & mask;
  assign limit_eff = (limit_q > LW'(lprf_pkg::MAX_RECORD)) ? LW'(lprf_pkg::MAX_RECORD)
                                                            : limit_q;
  assign hdr_sat   = (hdr > 16'd127) ? LW'(127) : hdr[LW-1:0];
  assign out_free  = !rsp.valid || rsp.ready;

  // status toward the sequencer
  always_comb begin
    st            = '0;
    st.action     = act_q;
    st.policy     = pol_q;
    st.btp_zero   = (btp == '0);
    st.too_long   = (rlen_q > LW'(lprf_pkg::MAX_RECORD)) || (CW'(need) > CW'(mask));
    st.no_space   = CW'(free_b) < CW'(need);
    st.used_zero  = (used_b == '0);
    st.iused_zero = (iused_b == '0);
    st.over_limit = hdr > 16'(limit_eff);
    st.hdr_zero   = (hdr == '0);
    st.purge_go   = st.no_space && !st.used_zero && (guard < size);
    st.last_byte  = (cnt + LW'(1)) == hdr[LW-1:0];
    st.out_free   = out_free;
  end

  // ring memory write select
  always_comb begin
    mem_we    = cmd.hdr_wr0 || cmd.hdr_wr1 || cmd.pbyte;
    mem_waddr = wcur;
    mem_wdata = dbyte_q;
    if (cmd.hdr_wr0) begin
      mem_waddr = head;
      mem_wdata = 8'd0;
    end else if (cmd.hdr_wr1) begin
      mem_waddr = (head + IW'(1)) & mask;
      mem_wdata = 8'(rlen_q);
    end
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) ring[mem_waddr] <= mem_wdata;
    if (cmd.mem_rd) rdata <= ring[ptr];
  end

  // item fields, read pointer, header and counters
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= action;
      rlen_q  <= record_length;
      pol_q   <= drop_policy;
      dbyte_q <= data_byte;
      limit_q <= read_limit;
    end
    if (cmd.ptr_tail) ptr <= tail;
    else if (cmd.ptr_itail) ptr <= itail;
    else if (cmd.mem_rd) ptr <= (ptr + IW'(1)) & mask;
    if (cmd.hdr_hi) hdr[15:8] <= rdata;
    if (cmd.hdr_lo) hdr[7:0] <= rdata;
    if (cmd.cnt_clr) cnt <= '0;
    else if (cmd.emit_data) cnt <= cnt + LW'(1);
    if (cmd.guard_clr) guard <= '0;
    else if (cmd.commit && act_q == lprf_pkg::ACT_PUSH_BEGIN) guard <= guard + (IW+1)'(1);
  end

  // ring indexes and record count
  always_ff @(posedge clk) begin
    if (rst) begin
      lg    <= lprf_pkg::LG_W'(10);
      head  <= '0;
      tail  <= '0;
      wcur  <= '0;
      btp   <= '0;
      recs  <= '0;
      itail <= '0;
      ihead <= '0;
    end else if (cfg_we) begin
      lg    <= cfg_data;
      head  <= '0;
      tail  <= '0;
      wcur  <= '0;
      btp   <= '0;
      recs  <= '0;
      itail <= '0;
      ihead <= '0;
    end else begin
      if (cmd.drop_all) begin
        head <= '0;
        tail <= '0;
        recs <= '0;
      end
      if (cmd.iter_start) begin
        itail <= tail;
        ihead <= head;
      end
      if (cmd.hdr_wr1) begin
        wcur <= (head + IW'(2)) & mask;
        btp  <= rlen_q;
        if (rlen_q == '0) begin
          head <= (head + IW'(2)) & mask;
          recs <= recs + 1'b1;
        end
      end
      if (cmd.pbyte) begin
        wcur <= (wcur + IW'(1)) & mask;
        btp  <= btp - LW'(1);
        if (btp == LW'(1)) begin
          head <= (wcur + IW'(1)) & mask;
          recs <= recs + 1'b1;
        end
      end
      if (cmd.commit) begin
        case (act_q)
          lprf_pkg::ACT_PUSH_BEGIN, lprf_pkg::ACT_SHIFT, lprf_pkg::ACT_DISCARD: begin
            tail <= adv_tail;
            if (recs != '0) recs <= recs - 1'b1;
          end
          lprf_pkg::ACT_ITER_NEXT: itail <= adv_itail;
          default: ;
        endcase
      end
    end
  end

  // result length select
  always_comb begin
    case (cmd.res_sel)
      lprf_pkg::LEN_RLEN: len_mux = rlen_q;
      lprf_pkg::LEN_BTP:  len_mux = btp;
      lprf_pkg::LEN_HDR:  len_mux = hdr_sat;
      default:            len_mux = '0;
    endcase
  end

  // output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_data) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (cmd.emit_single) begin
      rsp.status       <= cmd.res_status;
      rsp.out_byte     <= 8'd0;
      rsp.out_length   <= len_mux;
      rsp.byte_valid   <= 1'b0;
      rsp.last         <= 1'b1;
      rsp.record_count <= recs;
    end else if (cmd.emit_data) begin
      rsp.status       <= lprf_pkg::ST_OK;
      rsp.out_byte     <= rdata;
      rsp.out_length   <= hdr[LW-1:0];
      rsp.byte_valid   <= 1'b1;
      rsp.last         <= (cnt + LW'(1)) == hdr[LW-1:0];
      rsp.record_count <= recs;
    end
  end

  `LPRF_NEVER(a_emit_one_kind, clk, rst, cmd.emit_single && cmd.emit_data)
  `LPRF_ASSERT(a_emit_slot_free, clk, rst, (cmd.emit_single || cmd.emit_data) |-> out_free)
  `LPRF_ASSERT(a_push_bound, clk, rst, btp <= LW'(lprf_pkg::MAX_RECORD))
  `LPRF_ASSERT(a_idx_in_ring, clk, rst, ((head | tail | wcur) & ~mask) == '0)

endmodule

// ===== tb/sv/lprf_checker.sv =====
// Checker for the record FIFO: watches the cmd, rsp and register ports,
// predicts every result item and compares it. Depends on lprf_pkg and the two channel interfaces.
module lprf_checker (
  input  logic                       clk,
  input  logic                       rst,
  lprf_cmd_if                        cmd,
  lprf_rsp_if                        rsp,
  input  logic                       cfg_we,
  input  logic [lprf_pkg::LG_W-1:0]  cfg_data,
  output int                         failures,
  output int                         outstanding,
  output int                         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]                 status;
    logic [7:0]                 out_byte;
    logic [lprf_pkg::LEN_W-1:0] out_length;
    logic                       byte_valid;
    logic                       last;
    logic [lprf_pkg::CNT_W-1:0] record_count;
  } record_result_t;

  record_result_t expected_results[$];

  logic [7:0] ring_mem [lprf_pkg::RING_DEPTH];
  int head, tail, wcur, bytes_due, records, itail, ihead;
  int size_log2;

  function automatic int ring_mask();
    int lg, sz;
    lg = size_log2;
    if (lg < lprf_pkg::LG_MIN) lg = lprf_pkg::LG_MIN;
    if (lg > 10) lg = 10;
    sz = 1 << lg;
    while (sz > lprf_pkg::RING_DEPTH && sz > 4) sz = sz >> 1;
    return sz - 1;
  endfunction

  function automatic int header_len(int pos, int mask);
    return {ring_mem[pos & mask], ring_mem[(pos + 1) & mask]};
  endfunction

  function automatic void expect_result(logic [2:0] st, int b, int len, bit bv, bit lst);
    record_result_t r;
    r.status       = st;
    r.out_byte     = b[7:0];
    r.out_length   = len[lprf_pkg::LEN_W-1:0];
    r.byte_valid   = bv;
    r.last         = lst;
    r.record_count = records[lprf_pkg::CNT_W-1:0];
    expected_results.push_back(r);
  endfunction

  function automatic void clear_ring();
    head = 0; tail = 0; wcur = 0; bytes_due = 0; records = 0; itail = 0; ihead = 0;
  endfunction

  // Read out the record at pos; a shift also consumes it before the items are formed.
  function automatic void read_record(int pos, int lim, bit consume, int mask,
                                      output bit ok, output int n);
    n = header_len(pos, mask);
    if (lim > lprf_pkg::MAX_RECORD) lim = lprf_pkg::MAX_RECORD;
    ok = (n <= lim);
    if (!ok) begin
      expect_result(lprf_pkg::ST_OVER_LIMIT, 0, (n > 127) ? 127 : n, 0, 1);
      return;
    end
    if (consume) begin
      tail = (tail + n + 2) & mask;
      if (records > 0) records--;
    end
    if (n == 0) expect_result(lprf_pkg::ST_OK, 0, 0, 0, 1);
    else for (int i = 0; i < n; i++)
      expect_result(lprf_pkg::ST_OK, ring_mem[(pos + 2 + i) & mask], n, 1, i == n - 1);
  endfunction

  // Advance the shadow ring by one accepted request item.
  function automatic void predict_record_op(logic [2:0] act, int rlen, logic [1:0] pol,
                                            logic [7:0] db, int lim);
    int mask, need, len, guard, n;
    bit ok;
    mask = ring_mask();
    head &= mask; tail &= mask; wcur &= mask; ihead &= mask; itail &= mask;
    case (act)
      lprf_pkg::ACT_PUSH_BEGIN: begin
        need = rlen + 2;
        if (bytes_due != 0) begin
          expect_result(lprf_pkg::ST_PUSH_OPEN, 0, 0, 0, 1);
          return;
        end
        if (rlen > lprf_pkg::MAX_RECORD || need > mask) begin
          expect_result(lprf_pkg::ST_TOO_LONG, 0, 0, 0, 1);
          return;
        end
        if (pol == lprf_pkg::POL_TAIL) begin
          if (((tail - head - 1) & mask) < need) begin
            expect_result(lprf_pkg::ST_NO_SPACE, 0, 0, 0, 1);
            return;
          end
        end else if (pol == lprf_pkg::POL_HEAD) begin
          guard = 0;
          // purge oldest records until the new one fits
          while (((tail - head - 1) & mask) < need && ((head - tail) & mask) != 0
                 && guard <= mask) begin
            len = header_len(tail, mask);
            tail = (tail + len + 2) & mask;
            if (records > 0) records--;
            guard++;
          end
        end else if (pol == lprf_pkg::POL_ALL) begin
          head = 0; tail = 0; records = 0;
        end else begin
          expect_result(lprf_pkg::ST_BAD_POLICY, 0, 0, 0, 1);
          return;
        end
        ring_mem[head & mask] = 8'h00;
        ring_mem[(head + 1) & mask] = rlen[7:0];
        wcur = (head + 2) & mask;
        bytes_due = rlen;
        if (rlen == 0) begin
          head = wcur;
          records++;
        end
        expect_result(lprf_pkg::ST_OK, 0, rlen, 0, 1);
      end
      lprf_pkg::ACT_PUSH_BYTE: begin
        if (bytes_due == 0) begin
          expect_result(lprf_pkg::ST_EMPTY, 0, 0, 0, 1);
          return;
        end
        ring_mem[wcur & mask] = db;
        wcur = (wcur + 1) & mask;
        bytes_due--;
        if (bytes_due == 0) begin
          head = wcur;
          records++;
        end
        expect_result(lprf_pkg::ST_OK, 0, bytes_due, 0, 1);
      end
      lprf_pkg::ACT_SHIFT, lprf_pkg::ACT_PEEK: begin
        if (((head - tail) & mask) == 0) expect_result(lprf_pkg::ST_EMPTY, 0, 0, 0, 1);
        else read_record(tail, lim, act == lprf_pkg::ACT_SHIFT, mask, ok, n);
      end
      lprf_pkg::ACT_DISCARD: begin
        if (((head - tail) & mask) == 0) begin
          expect_result(lprf_pkg::ST_EMPTY, 0, 0, 0, 1);
          return;
        end
        len = header_len(tail, mask);
        tail = (tail + len + 2) & mask;
        if (records > 0) records--;
        expect_result(lprf_pkg::ST_OK, 0, (len > 127) ? 127 : len, 0, 1);
      end
      lprf_pkg::ACT_ITER_START: begin
        itail = tail;
        ihead = head;
        expect_result(lprf_pkg::ST_OK, 0, 0, 0, 1);
      end
      lprf_pkg::ACT_ITER_NEXT: begin
        if (((ihead - itail) & mask) == 0) expect_result(lprf_pkg::ST_EMPTY, 0, 0, 0, 1);
        else begin
          read_record(itail, lim, 0, mask, ok, n);
          if (ok) itail = (itail + n + 2) & mask;
        end
      end
      default: expect_result(lprf_pkg::ST_OK, 0, 0, 0, 1);
    endcase
  endfunction

  task automatic report(string field, int got, int want);
    $display("%0t mismatch on %s: got %0d expected %0d", $realtime, field, got, want);
    failures++;
  endtask

  // Compare the oldest expectation first, then predict from a newly taken request.
  always @(posedge clk) begin
    record_result_t want;
    if (rst) begin
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      size_log2 = 10;
      clear_ring();
      expected_results.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_results.size() == 0) report("unexpected item", 1, 0);
        else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.out_byte !== want.out_byte) report("out_byte", rsp.out_byte, want.out_byte);
          if (rsp.out_length !== want.out_length)
            report("out_length", rsp.out_length, want.out_length);
          if (rsp.byte_valid !== want.byte_valid)
            report("byte_valid", rsp.byte_valid, want.byte_valid);
          if (rsp.last !== want.last) report("last", rsp.last, want.last);
          if (rsp.record_count !== want.record_count)
            report("record_count", rsp.record_count, want.record_count);
        end
      end
      if (cfg_we) begin
        size_log2 = cfg_data;
        clear_ring();
      end
      if (cmd.valid && cmd.ready)
        predict_record_op(cmd.action, cmd.record_length, cmd.drop_policy, cmd.data_byte,
                          cmd.read_limit);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/sv/tb_length_prefixed_record_fifo_top.sv =====
// Testbench top for the record FIFO: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on lprf_pkg, the channel interfaces and lprf_checker.
module tb_length_prefixed_record_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] POL_UNSUPPORTED = 2'd3;
  localparam logic [2:0] ACT_UNUSED      = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lprf_pkg::LG_W-1:0] cfg_data = '0;
  int failures, outstanding, results_seen;
  int items_sent = 0;
  int long_hold_req = 0;
  bit send_quiet = 0;

  lprf_cmd_if cmd ();
  lprf_rsp_if rsp ();

  length_prefixed_record_fifo_top dut (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  lprf_checker chk (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding), .results_seen(results_seen)
  );

  always #1 clk = ~clk;

  // Hold the result side off for random stretches, with quiet runs and one long stall.
  initial begin
    int hold;
    bit quiet;
    hold = 0;
    quiet = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req != 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        hold--;
      end else begin
        rsp.ready <= 1'b1;
        if (rsp.valid && rsp.ready) begin
          if ($urandom_range(0, 40) == 0) quiet = ~quiet;
          hold = quiet ? 0 : $urandom_range(0, 10);
        end
      end
    end
  end

  // Offer one item and return at the edge where it is taken.
  task automatic send(logic [2:0] act, int rlen, logic [1:0] pol, int db, int lim);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.action <= act;
    cmd.record_length <= rlen[lprf_pkg::LEN_W-1:0];
    cmd.drop_policy <= pol;
    cmd.data_byte <= db[7:0];
    cmd.read_limit <= lim[lprf_pkg::LEN_W-1:0];
    do @(posedge clk); while (!cmd.ready);
    items_sent++;
  endtask

  // Stop offering and wait until every expected item has come back.
  task automatic drain();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(int lg);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= lg[lprf_pkg::LG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_record(int rlen, logic [1:0] pol);
    send(lprf_pkg::ACT_PUSH_BEGIN, rlen, pol, $urandom, $urandom_range(0, 127));
    for (int i = 0; i < rlen; i++)
      send(lprf_pkg::ACT_PUSH_BYTE, $urandom_range(0, 127), 2'($urandom), $urandom,
           $urandom_range(0, 127));
  endtask

  function automatic int pick_limit();
    return ($urandom_range(0, 1) != 0) ? $urandom_range(64, 127) : $urandom_range(0, 64);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(0, 6);
    if (r < 9) return $urandom_range(7, 64);
    return $urandom_range(65, 127);
  endfunction

  // One random step: mostly whole records and reads, some noise.
  task automatic random_step();
    int r, rlen, cut, nbytes;
    logic [1:0] pol;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      rlen = pick_length();
      pol = ($urandom_range(0, 19) == 0) ? POL_UNSUPPORTED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0 && pol == lprf_pkg::POL_ALL) pol = lprf_pkg::POL_HEAD;
      cut = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3) : 0;
      // a record that is too long only gets a couple of stray bytes
      nbytes = (rlen > lprf_pkg::MAX_RECORD) ? 2 : rlen - cut;
      send(lprf_pkg::ACT_PUSH_BEGIN, rlen, pol, $urandom, pick_limit());
      for (int i = 0; i < nbytes; i++)
        send(lprf_pkg::ACT_PUSH_BYTE, $urandom, 2'($urandom), $urandom, pick_limit());
    end else if (r < 55)
      send(lprf_pkg::ACT_SHIFT, $urandom, 2'($urandom), $urandom, pick_limit());
    else if (r < 65)
      send(lprf_pkg::ACT_PEEK, $urandom, 2'($urandom), $urandom, pick_limit());
    else if (r < 72)
      send(lprf_pkg::ACT_DISCARD, $urandom, 2'($urandom), $urandom, pick_limit());
    else if (r < 78)
      send(lprf_pkg::ACT_ITER_START, $urandom, 2'($urandom), $urandom, pick_limit());
    else if (r < 88)
      send(lprf_pkg::ACT_ITER_NEXT, $urandom, 2'($urandom), $urandom, pick_limit());
    else if (r < 93)
      send(lprf_pkg::ACT_PUSH_BYTE, $urandom, 2'($urandom), $urandom, pick_limit());
    else if (r < 96) send(ACT_UNUSED, $urandom, 2'($urandom), $urandom, $urandom);
    else send(3'($urandom), $urandom, 2'($urandom), $urandom, $urandom);
  endtask

  initial begin
    int sizes [6] = '{4, 2, 0, 15, 6, 10};
    cmd.valid <= 1'b0;
    cmd.action <= '0;
    cmd.record_length <= '0;
    cmd.drop_policy <= '0;
    cmd.data_byte <= '0;
    cmd.read_limit <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed on a 16-byte ring: two records leave one byte free.
    write_size(4);
    push_record(5, lprf_pkg::POL_TAIL);
    push_record(5, lprf_pkg::POL_TAIL);

    // Directed: field extremes, error codes, every action.
    send(lprf_pkg::ACT_PUSH_BEGIN, 127, lprf_pkg::POL_TAIL, 0, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 65, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 14, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 1, POL_UNSUPPORTED, 0, 0);
    send(lprf_pkg::ACT_PUSH_BYTE, 0, lprf_pkg::POL_HEAD, 8'hFF, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 0, lprf_pkg::POL_TAIL, 0, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 2, lprf_pkg::POL_HEAD, 0, 127);
    send(lprf_pkg::ACT_PUSH_BEGIN, 1, lprf_pkg::POL_HEAD, 0, 127);
    send(lprf_pkg::ACT_PUSH_BYTE, 0, lprf_pkg::POL_HEAD, 8'h00, 127);
    send(lprf_pkg::ACT_PUSH_BYTE, 0, lprf_pkg::POL_HEAD, 8'hFF, 127);
    send(lprf_pkg::ACT_PEEK, 0, lprf_pkg::POL_HEAD, 0, 127);
    send(lprf_pkg::ACT_SHIFT, 0, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_SHIFT, 0, lprf_pkg::POL_HEAD, 0, 5);
    send(lprf_pkg::ACT_ITER_START, 0, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_ITER_NEXT, 0, lprf_pkg::POL_HEAD, 0, 64);
    send(lprf_pkg::ACT_ITER_NEXT, 0, lprf_pkg::POL_HEAD, 0, 64);
    send(lprf_pkg::ACT_DISCARD, 0, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 0, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_PEEK, 0, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_SHIFT, 0, lprf_pkg::POL_HEAD, 0, 0);
    send(lprf_pkg::ACT_PUSH_BEGIN, 1, lprf_pkg::POL_ALL, 0, 0);
    send(lprf_pkg::ACT_PUSH_BYTE, 0, lprf_pkg::POL_HEAD, 8'hAA, 0);
    send(lprf_pkg::ACT_SHIFT, 0, lprf_pkg::POL_HEAD, 0, 64);
    send(lprf_pkg::ACT_SHIFT, 0, lprf_pkg::POL_HEAD, 0, 64);
    send(lprf_pkg::ACT_DISCARD, 0, lprf_pkg::POL_HEAD, 0, 64);
    send(lprf_pkg::ACT_ITER_NEXT, 0, lprf_pkg::POL_HEAD, 0, 64);
    send(ACT_UNUSED, 127, POL_UNSUPPORTED, 8'hFF, 127);

    // Random phases over several ring sizes, smallest and largest among them.
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      send_quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 18; ) begin
        random_step();
        n++;
        if (n == 9 && p == 1) begin
          // long result stall while requests keep coming
          long_hold_req = 400;
        end
        if (n == 12 && p == 3) drain();
      end
    end

    drain();
    $display("Sent %0d request items and checked %0d result items", items_sent, results_seen);
    $display("over ring sizes 4..1024 with all actions, drop policies and error codes.");
    if (failures == 0) begin
      $display("tb_length_prefixed_record_fifo_top: PASS");
    end else begin
      $display("tb_length_prefixed_record_fifo_top: FAIL");
    end
    $finish;
  end

  // Bound the run in case the block hangs.
  initial begin
    #20ms;
    $display("tb_length_prefixed_record_fifo_top: FAIL");
    $finish;
  end

endmodule
